@@ design/qbl_pkg.sv @@
// Shared types and constants for the quiz buzzer lockout arbiter.
package qbl_pkg;

	localparam int BUTTONS     = 4;
	localparam int FIELD_LANES = 4;
	localparam int LANES       = (BUTTONS < FIELD_LANES) ? BUTTONS : FIELD_LANES;
	localparam int LANE_W      = $clog2(FIELD_LANES);
	localparam int TIME_W      = 32;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 48;

	typedef enum logic [2:0] {
		ACT_POLL   = 3'd0,
		ACT_ARM    = 3'd1,
		ACT_DISARM = 3'd2,
		ACT_GO     = 3'd3,
		ACT_ENTER  = 3'd4,
		ACT_TICK   = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		MODE_FIRST  = 2'd0,
		MODE_CONT   = 2'd1,
		MODE_REPEAT = 2'd2
	} mode_t;

	localparam logic KIND_BUZZ   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// state as it passes from one cell to the next
	typedef struct packed {
		logic [FIELD_LANES-1:0] armed;
		logic [FIELD_LANES-1:0] leds;
		logic                   fired;
	} chain_t;

	// all results of one item, ready to be sent out
	typedef struct packed {
		logic [FIELD_LANES-1:0] rep_vld;
		chain_t [FIELD_LANES-1:0] rep;
		logic [TIME_W-1:0]      el_rep;
		chain_t                 stat;
		logic [TIME_W-1:0]      el_stat;
	} batch_t;

endpackage

@@ design/qbl_cell.sv @@
// One button cell: holds the armed and LED bits of its button and updates the chain.
module qbl_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [qbl_pkg::LANE_W-1:0] idx,
	input  logic                       take,
	input  qbl_pkg::act_t              action,
	input  logic                       mask_bit,
	input  logic                       press_bit,
	input  logic                       en,
	input  logic                       mode_first,
	input  logic                       mode_cont,
	input  qbl_pkg::chain_t            chain_in,
	input  qbl_pkg::chain_t            chain_fin,
	output qbl_pkg::chain_t            chain_out,
	output logic                       hit,
	output logic                       armed_bit,
	output logic                       led_bit
);
	import qbl_pkg::*;

	logic armed_q;
	logic led_q;

	assign hit = (action == ACT_POLL) && en && chain_in.armed[idx] && press_bit;

	always_comb begin
		chain_out = chain_in;
		unique case (action)
			ACT_POLL: begin
				if (hit && mode_first) begin
					chain_out.armed     = '0;
					chain_out.leds[idx] = 1'b1;
					chain_out.fired     = 1'b1;
				end else if (hit && mode_cont) begin
					chain_out.armed[idx] = 1'b0;
				end
			end
			ACT_ARM: begin
				chain_out.armed[idx] = mask_bit;
				chain_out.fired      = 1'b0;
			end
			ACT_DISARM: begin
				chain_out.armed[idx] = 1'b0;
				chain_out.fired      = 1'b0;
			end
			ACT_GO: begin
				chain_out.leds[idx] = mask_bit;
			end
			ACT_ENTER: begin
				chain_out.armed[idx] = 1'b0;
				chain_out.leds[idx]  = 1'b0;
				chain_out.fired      = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			led_q   <= 1'b0;
		end else if (take) begin
			armed_q <= chain_fin.armed[idx];
			led_q   <= chain_fin.leds[idx];
		end
	end

	assign armed_bit = armed_q;
	assign led_bit   = led_q;

endmodule

@@ design/qbl_out.sv @@
// Result sender: two batch slots, reports in button order, then the status item.
module qbl_out (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  qbl_pkg::batch_t                batch,
	output logic                           room,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [qbl_pkg::OUT_DATA_W-1:0] m_tdata,  // button, elapsed_ms, leds, armed, fired_flag
	output logic                           m_tuser,  // kind
	output logic                           m_tlast
);
	import qbl_pkg::*;

	logic                   a_vld_q;
	logic                   b_vld_q;
	batch_t                 a_q;
	batch_t                 b_q;
	logic [FIELD_LANES-1:0] pend_q;
	logic [LANE_W-1:0]      sel;
	logic                   is_rep;
	logic                   fire;
	logic                   done;
	chain_t                 snap;
	logic [TIME_W-1:0]      el;

	always_comb begin
		sel = '0;
		for (int i = FIELD_LANES - 1; i >= 0; i--) begin
			if (pend_q[i])
				sel = LANE_W'(i);
		end
	end

	assign is_rep = (pend_q != '0);
	assign fire   = a_vld_q && m_tready;
	assign done   = fire && !is_rep;
	assign room   = !b_vld_q;
	assign snap   = is_rep ? a_q.rep[sel] : a_q.stat;
	assign el     = is_rep ? a_q.el_rep : a_q.el_stat;

	assign m_tvalid = a_vld_q;
	assign m_tuser  = is_rep ? KIND_BUZZ : KIND_STATUS;
	assign m_tlast  = !is_rep;
	assign m_tdata  = {5'b0, snap.fired, snap.armed, snap.leds, el,
		(is_rep ? sel : LANE_W'(0))};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_q <= 1'b0;
			b_vld_q <= 1'b0;
			pend_q  <= '0;
		end else begin
			if (fire && is_rep) begin
				pend_q <= pend_q & (pend_q - FIELD_LANES'(1));
			end else if (done) begin
				if (b_vld_q) begin
					pend_q  <= b_q.rep_vld;
					b_vld_q <= 1'b0;
				end else if (take) begin
					pend_q <= batch.rep_vld;
				end else begin
					a_vld_q <= 1'b0;
				end
			end
			if (take && !done) begin
				if (!a_vld_q) begin
					a_vld_q <= 1'b1;
					pend_q  <= batch.rep_vld;
				end else begin
					b_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done && b_vld_q)
			a_q <= b_q;
		else if (take && (done || !a_vld_q))
			a_q <= batch;
		if (take && a_vld_q && !done)
			b_q <= batch;
	end

	a_slot_fill: assert property (@(posedge clk) disable iff (!arst_n)
		b_vld_q |-> a_vld_q) else $error("second slot filled ahead of first");
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != '0) |-> a_vld_q) else $error("reports pending in empty slot");

endmodule

@@ design/quiz_buzzer_lockout_arbiter_top.sv @@
// Quiz buzzer lockout arbiter: a row of button cells and the result sender.
//
// Input channel s_*: one item per handshake; s_tuser carries the action
// (poll, arm, disarm, go, enter, tick), s_tdata the mask, mode and presses.
// Output channel m_*: a poll gives one buzz item per reporting button, in
// button order, then a status item; every other action gives the status
// item only. m_tuser is the kind, m_tlast marks the status item.
// An accepted item is worked through the cell row in its cycle of
// acceptance; its results are registered in a sender slot and sent after
// older ones. The sender holds two items' results, so input is taken
// while results wait. Throughput: one item per cycle while each gives
// one result and m_tready is high; a poll gives up to five results.
// Reset clears the armed mask, LEDs, fired flag, mode and clock. A stall
// on m_tready holds the current result; once both slots are full
// s_tready drops until the older item's status item is taken.
module quiz_buzzer_lockout_arbiter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [qbl_pkg::IN_DATA_W-1:0]  s_tdata,  // mask, report_mode, pressed
	input  logic [2:0]                     s_tuser,  // action
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [qbl_pkg::OUT_DATA_W-1:0] m_tdata,  // button, elapsed_ms, leds, armed, fired_flag
	output logic                           m_tuser,  // kind
	output logic                           m_tlast
);
	import qbl_pkg::*;

	logic                   take;
	act_t                   action;
	logic [3:0]             mask;
	logic [1:0]             report_mode;
	logic [3:0]             pressed;
	logic                   fired_q;
	logic [1:0]             mode_q;
	logic [TIME_W-1:0]      elapsed_q;
	logic [TIME_W-1:0]      elapsed_nx;
	logic [FIELD_LANES-1:0] armed_vec;
	logic [FIELD_LANES-1:0] led_vec;
	logic [FIELD_LANES-1:0] hit;
	logic                   en;
	chain_t                 chain [LANES+1];
	batch_t                 batch;

	assign take        = s_tvalid && s_tready;
	assign action      = act_t'(s_tuser);
	assign mask        = s_tdata[3:0];
	assign report_mode = s_tdata[5:4];
	assign pressed     = s_tdata[9:6];

	assign en = (armed_vec != '0) && !fired_q;
	assign chain[0] = '{armed: armed_vec, leds: led_vec, fired: fired_q};

	for (genvar i = 0; i < FIELD_LANES; i++) begin : g_lane
		if (i < LANES) begin : g_cell
			qbl_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.idx        (LANE_W'(i)),
				.take       (take),
				.action     (action),
				.mask_bit   (mask[i]),
				.press_bit  (pressed[i]),
				.en         (en),
				.mode_first (mode_q == MODE_FIRST),
				.mode_cont  (mode_q == MODE_CONT),
				.chain_in   (chain[i]),
				.chain_fin  (chain[LANES]),
				.chain_out  (chain[i+1]),
				.hit        (hit[i]),
				.armed_bit  (armed_vec[i]),
				.led_bit    (led_vec[i])
			);
			assign batch.rep[i] = chain[i+1];
		end else begin : g_none
			assign hit[i]       = 1'b0;
			assign armed_vec[i] = 1'b0;
			assign led_vec[i]   = 1'b0;
			assign batch.rep[i] = '0;
		end
	end

	always_comb begin
		elapsed_nx = elapsed_q;
		unique case (action)
			ACT_ARM, ACT_GO: elapsed_nx = '0;
			ACT_TICK:        elapsed_nx = elapsed_q + TIME_W'(1);
			default:         elapsed_nx = elapsed_q;
		endcase
	end

	assign batch.rep_vld = hit;
	assign batch.el_rep  = elapsed_q;
	assign batch.stat    = chain[LANES];
	assign batch.el_stat = elapsed_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q   <= 1'b0;
			mode_q    <= MODE_FIRST;
			elapsed_q <= '0;
		end else if (take) begin
			fired_q   <= chain[LANES].fired;
			elapsed_q <= elapsed_nx;
			if (action == ACT_ARM)
				mode_q <= report_mode;
			else if (action == ACT_DISARM || action == ACT_ENTER)
				mode_q <= MODE_FIRST;
		end
	end

	qbl_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.batch    (batch),
		.room     (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_fired_locked: assert property (@(posedge clk) disable iff (!arst_n)
		fired_q |-> (armed_vec == '0)) else $error("fired while still armed");
	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take && action == ACT_TICK) |=> (elapsed_q == $past(elapsed_q) + TIME_W'(1)))
		else $error("tick did not advance clock");
	a_arm_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (action == ACT_ARM || action == ACT_GO)) |=> (elapsed_q == '0))
		else $error("time not restamped");

endmodule

@@ tb/quiz_buzzer_lockout_arbiter_checker.sv @@
`timescale 1ns / 100ps
// Checker for the quiz buzzer arbiter: predicts each item's results and compares them.
module quiz_buzzer_lockout_arbiter_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [qbl_pkg::IN_DATA_W-1:0]    s_tdata,   // mask, report_mode, pressed
	input  logic [2:0]                       s_tuser,   // action
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [qbl_pkg::OUT_DATA_W-1:0]   m_tdata,   // button, elapsed_ms, leds, armed, fired_flag
	input  logic                             m_tuser,   // kind
	input  logic                             m_tlast,
	output int                               fail_count,
	output int                               pending
);
	import qbl_pkg::*;

	typedef struct packed {
		logic                   kind;
		logic [LANE_W-1:0]      button;
		logic [TIME_W-1:0]      elapsed;
		logic [FIELD_LANES-1:0] leds;
		logic [FIELD_LANES-1:0] armed;
		logic                   fired;
		logic                   last;
	} buzz_res_t;

	localparam logic [FIELD_LANES-1:0] LANE_MASK = FIELD_LANES'((1 << LANES) - 1);

	buzz_res_t              buzz_q[$];
	logic [FIELD_LANES-1:0] armed_set;
	logic [FIELD_LANES-1:0] lamps;
	logic                   fired;
	logic [1:0]             round_mode;
	logic [TIME_W-1:0]      start_ms;
	logic [TIME_W-1:0]      now_ms;

	function automatic buzz_res_t snapshot(logic kind, logic [LANE_W-1:0] btn);
		buzz_res_t r;
		r.kind    = kind;
		r.button  = btn;
		r.elapsed = now_ms - start_ms;
		r.leds    = lamps;
		r.armed   = armed_set;
		r.fired   = fired;
		r.last    = (kind == KIND_STATUS);
		return r;
	endfunction

	task automatic report(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic buzz_scan(logic [2:0] act, logic [3:0] mask, logic [1:0] mode,
			logic [3:0] press);
		logic [FIELD_LANES-1:0] bit_m;
		logic                   stop;
		stop = 1'b0;
		case (act)
		ACT_POLL: begin
			if (armed_set != '0 && !fired) begin
				for (int i = 0; i < LANES; i++) begin
					bit_m = FIELD_LANES'(1) << i;
					if (!stop && (armed_set & bit_m) != '0 && (press & bit_m) != '0) begin
						if (round_mode == MODE_CONT) begin
							armed_set = armed_set & ~bit_m;
						end else if (round_mode == MODE_FIRST) begin
							fired     = 1'b1;
							armed_set = '0;
							lamps     = lamps | bit_m;
						end
						buzz_q.push_back(snapshot(KIND_BUZZ, LANE_W'(i)));
						if (round_mode == MODE_FIRST)
							stop = 1'b1;
					end
				end
			end
		end
		ACT_ARM: begin
			armed_set  = mask & LANE_MASK;
			round_mode = mode;
			start_ms   = now_ms;
			fired      = 1'b0;
		end
		ACT_DISARM: begin
			armed_set  = '0;
			fired      = 1'b0;
			round_mode = MODE_FIRST;
		end
		ACT_GO: begin
			lamps    = mask & LANE_MASK;
			start_ms = now_ms;
		end
		ACT_ENTER: begin
			armed_set  = '0;
			fired      = 1'b0;
			round_mode = MODE_FIRST;
			lamps      = '0;
		end
		ACT_TICK: now_ms = now_ms + 1'b1;
		default: ;
		endcase
		buzz_q.push_back(snapshot(KIND_STATUS, '0));
	endtask

	task automatic check_result(buzz_res_t w);
		if (m_tuser !== w.kind)               report("kind", m_tuser, w.kind);
		if (m_tdata[1:0] !== w.button)        report("button", m_tdata[1:0], w.button);
		if (m_tdata[33:2] !== w.elapsed)      report("elapsed_ms", m_tdata[33:2], w.elapsed);
		if (m_tdata[37:34] !== w.leds)        report("leds", m_tdata[37:34], w.leds);
		if (m_tdata[41:38] !== w.armed)       report("armed", m_tdata[41:38], w.armed);
		if (m_tdata[42] !== w.fired)          report("fired_flag", m_tdata[42], w.fired);
		if (m_tlast !== w.last)               report("last", m_tlast, w.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_set  = '0;
			lamps      = '0;
			fired      = 1'b0;
			round_mode = MODE_FIRST;
			start_ms   = '0;
			now_ms     = '0;
			fail_count = 0;
			pending    = 0;
			buzz_q.delete();
		end else begin
			// results first: an item taken at this edge cannot have a result out yet
			if (m_tvalid && m_tready) begin
				if (buzz_q.size() == 0)
					report("unexpected result", m_tdata[33:2], '0);
				else
					check_result(buzz_q.pop_front());
			end
			if (s_tvalid && s_tready)
				buzz_scan(s_tuser, s_tdata[3:0], s_tdata[5:4], s_tdata[9:6]);
			pending = buzz_q.size();
		end
	end

endmodule

@@ tb/quiz_buzzer_lockout_arbiter_top_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the quiz buzzer arbiter: clock, reset, stimulus and verdict.
module quiz_buzzer_lockout_arbiter_top_test;
	import qbl_pkg::*;

	localparam int         ITEMS       = 260;
	localparam int         HOLD_CYCLES = 80;
	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;
	localparam logic [1:0] MODE_SPARE  = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // mask, report_mode, pressed
	logic [2:0]            s_tuser;   // action
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // button, elapsed_ms, leds, armed, fired_flag
	logic                  m_tuser;   // kind
	logic                  m_tlast;
	int                    fail_count;
	int                    pending;
	int                    sent = 0;
	logic                  calm = 1'b0;
	logic                  hold_ask = 1'b0;

	always #10 clk = ~clk;

	quiz_buzzer_lockout_arbiter_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	quiz_buzzer_lockout_arbiter_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.fail_count(fail_count),
		.pending   (pending)
	);

	task automatic put_item(logic [2:0] act, logic [3:0] mask, logic [1:0] mode,
			logic [3:0] press);
		calm = (sent >= 90 && sent < 150);
		while (!calm && $urandom_range(0, 99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {6'b0, press, mode, mask};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic put_poll(logic [3:0] press);
		put_item(ACT_POLL, 4'($urandom), 2'($urandom), press);
	endtask

	task automatic put_tick();
		put_item(ACT_TICK, 4'($urandom), 2'($urandom), 4'($urandom));
	endtask

	initial begin
		logic [1:0] mode;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= ACT_POLL;
		s_tdata  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		put_poll(4'hF);                             // idle poll after reset
		put_tick();
		put_item(ACT_ARM, 4'hF, MODE_FIRST, 4'h0);
		put_tick();
		put_tick();
		put_poll(4'h0);
		put_poll(4'hF);                             // lowest button wins
		put_poll(4'hF);                             // locked out after firing
		put_item(ACT_ARM, 4'hC, MODE_FIRST, 4'hF);
		put_poll(4'h8);
		put_item(ACT_GO, 4'hF, 2'd0, 4'h0);
		put_item(ACT_GO, 4'h0, 2'd3, 4'hF);
		put_item(ACT_ARM, 4'hF, MODE_CONT, 4'h0);
		put_poll(4'h5);
		put_poll(4'hF);
		put_poll(4'hF);                             // mask now empty
		put_item(ACT_ARM, 4'hF, MODE_REPEAT, 4'h0);
		put_poll(4'hF);                             // four reports and status
		put_item(ACT_ARM, 4'h6, MODE_SPARE, 4'h0);
		put_poll(4'hF);
		put_item(ACT_DISARM, 4'hF, 2'd3, 4'hF);
		put_item(ACT_ENTER, 4'hF, 2'd3, 4'hF);
		put_item(ACT_SPARE_A, 4'hF, 2'd3, 4'hF);
		put_item(ACT_SPARE_B, 4'h0, 2'd0, 4'h0);

		// random rounds with some noise
		while (sent < ITEMS) begin
			if ($urandom_range(0, 99) < 12) begin
				put_item(3'($urandom_range(0, 7)), 4'($urandom), 2'($urandom), 4'($urandom));
			end else begin
				mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
				put_item(ACT_ARM, 4'($urandom), mode, 4'($urandom));
				repeat ($urandom_range(0, 3)) put_tick();
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 3) == 0)
						put_tick();
					put_poll(4'($urandom));
				end
				case ($urandom_range(0, 5))
				0: put_item(ACT_GO, 4'($urandom), 2'($urandom), 4'($urandom));
				1: put_item(ACT_DISARM, 4'($urandom), 2'($urandom), 4'($urandom));
				2: put_item(ACT_ENTER, 4'($urandom), 2'($urandom), 4'($urandom));
				default: ;
				endcase
			end
			if (sent >= 170 && !hold_ask) begin
				// receiver stalls while repeat-mode polls pile up
				hold_ask = 1'b1;
				put_item(ACT_ARM, 4'hF, MODE_REPEAT, 4'h0);
				repeat (12) put_poll(4'($urandom));
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic hold_done;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 21);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ quiz_buzzer_lockout_arbiter_top.f @@
design/qbl_pkg.sv
design/qbl_cell.sv
design/qbl_out.sv
design/quiz_buzzer_lockout_arbiter_top.sv
tb/quiz_buzzer_lockout_arbiter_checker.sv
tb/quiz_buzzer_lockout_arbiter_top_test.sv
